// ===== hdl/x86_16_instruction_decoder_assert.svh =====
// Assertion macros for the x86 16-bit instruction decoder.
// Expects signals named clk and rst_n in the including module.
`ifndef X86_16_INSTRUCTION_DECODER_ASSERT_SVH
`define X86_16_INSTRUCTION_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define X86D_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("x86d: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define X86D_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("x86d: next-cycle check failed");

`endif

// ===== hdl/x86d_pkg.sv =====
// Shared types, codes and opcode field decode for the x86 16-bit decoder.
// No dependencies; used by the gather, record and top-level modules.
`timescale 1ns / 1ps
`default_nettype none

package x86d_pkg;

  // Instruction form, from the opcode byte
  typedef enum logic [2:0] {
    CL_NONE  = 3'd0,
    CL_RM    = 3'd1,
    CL_IMOV  = 3'd2,
    CL_IGRP  = 3'd3,
    CL_IREG  = 3'd4,
    CL_LOAD  = 3'd5,
    CL_STORE = 3'd6
  } form_t;

  // Mnemonic codes
  localparam logic [1:0] OP_MOV = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_SUB = 2'd2;
  localparam logic [1:0] OP_CMP = 2'd3;

  // Operand kind codes
  localparam logic [1:0] KIND_REG    = 2'd0;
  localparam logic [1:0] KIND_MEM    = 2'd1;
  localparam logic [1:0] KIND_DIRECT = 2'd2;
  localparam logic [1:0] KIND_IMM    = 2'd3;

  // Opcode patterns
  localparam logic [5:0] TOP6_MOV_RM = 6'b100010;
  localparam logic [5:0] TOP6_ADD_RM = 6'b000000;
  localparam logic [5:0] TOP6_SUB_RM = 6'b001010;
  localparam logic [5:0] TOP6_CMP_RM = 6'b001110;
  localparam logic [6:0] TOP7_IMOV   = 7'b1100011;
  localparam logic [5:0] TOP6_IGRP   = 6'b100000;
  localparam logic [3:0] TOP4_IREG   = 4'b1011;
  localparam logic [6:0] TOP7_LOAD   = 7'b1010000;
  localparam logic [6:0] TOP7_STORE  = 7'b1010001;

  // Group codes in the 80-83 reg field
  localparam logic [2:0] GRP_ADD = 3'b000;
  localparam logic [2:0] GRP_SUB = 3'b101;
  localparam logic [2:0] GRP_CMP = 3'b111;

  // mod/rm special values
  localparam logic [1:0] MOD_NODISP = 2'b00;
  localparam logic [1:0] MOD_DISP8  = 2'b01;
  localparam logic [1:0] MOD_DISP16 = 2'b10;
  localparam logic [1:0] MOD_REG    = 2'b11;
  localparam logic [2:0] RM_DIRECT  = 3'b110;

  // Instruction bytes gathered so far
  typedef struct packed {
    logic [7:0]  first_byte;
    logic [7:0]  modrm_byte;
    logic [15:0] disp_acc;
    logic [15:0] imm_acc;
    logic [2:0]  byte_count;
  } dec_state_t;

  // One result record
  typedef struct packed {
    logic        status;
    logic [1:0]  op;
    logic        wide;
    logic [1:0]  dst_kind;
    logic [2:0]  dst_reg;
    logic [1:0]  src_kind;
    logic [2:0]  src_reg;
    logic [2:0]  ea_code;
    logic [15:0] disp;
    logic [1:0]  disp_bytes;
    logic [15:0] imm;
    logic [2:0]  length;
  } rec_t;

  function automatic form_t form_of(input logic [7:0] b);
    form_t f;
    f = CL_NONE;
    if (b[7:2] == TOP6_MOV_RM || b[7:2] == TOP6_ADD_RM ||
        b[7:2] == TOP6_SUB_RM || b[7:2] == TOP6_CMP_RM) begin
      f = CL_RM;
    end else if (b[7:1] == TOP7_IMOV) begin
      f = CL_IMOV;
    end else if (b[7:2] == TOP6_IGRP) begin
      f = CL_IGRP;
    end else if (b[7:4] == TOP4_IREG) begin
      f = CL_IREG;
    end else if (b[7:1] == TOP7_LOAD) begin
      f = CL_LOAD;
    end else if (b[7:1] == TOP7_STORE) begin
      f = CL_STORE;
    end
    return f;
  endfunction

  function automatic logic has_modrm(input form_t f);
    return (f == CL_RM) || (f == CL_IMOV) || (f == CL_IGRP);
  endfunction

  // Displacement bytes that follow mod/rm (or the opcode for A0-A3)
  function automatic logic [1:0] disp_len(input form_t f, input logic [7:0] m);
    logic [1:0] n;
    n = 2'd0;
    if (f == CL_LOAD || f == CL_STORE) begin
      n = 2'd2;
    end else if (has_modrm(f)) begin
      if (m[7:6] == MOD_DISP8) begin
        n = 2'd1;
      end else if (m[7:6] == MOD_DISP16) begin
        n = 2'd2;
      end else if (m[7:6] == MOD_NODISP && m[2:0] == RM_DIRECT) begin
        n = 2'd2;
      end
    end
    return n;
  endfunction

  // Immediate bytes
  function automatic logic [1:0] imm_len(input form_t f, input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if (f == CL_IMOV) begin
      n = b[0] ? 2'd2 : 2'd1;
    end else if (f == CL_IGRP) begin
      n = (!b[1] && b[0]) ? 2'd2 : 2'd1;
    end else if (f == CL_IREG) begin
      n = b[3] ? 2'd2 : 2'd1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/x86d_gather.sv =====
// Byte gathering state machine: tracks the instruction phase and collects
// opcode, mod/rm, displacement and immediate bytes. Uses x86d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module x86d_gather (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,      // consume code_byte this cycle
  input  wire logic [7:0]            code_byte,
  output x86d_pkg::dec_state_t       st_nxt,    // state including this byte
  output logic                       fire,      // instruction complete
  output logic                       err        // unknown opcode or group code
);

  typedef enum logic [2:0] {
    PH_OPC   = 3'd0,
    PH_MODRM = 3'd1,
    PH_DLO   = 3'd2,
    PH_DHI   = 3'd3,
    PH_ILO   = 3'd4,
    PH_IHI   = 3'd5
  } phase_t;

  phase_t               phase_r, phase_nxt;
  x86d_pkg::dec_state_t st_r;
  x86d_pkg::form_t      form_cur, form_new;
  logic [1:0]           dlen, ilen;
  logic [2:0]           grp;

  assign form_cur = x86d_pkg::form_of(st_r.first_byte);
  assign form_new = x86d_pkg::form_of(code_byte);
  assign grp      = code_byte[5:3];

  // Displacement and immediate sizes follow the updated bytes
  always_comb begin
    dlen = x86d_pkg::disp_len(x86d_pkg::form_of(st_nxt.first_byte), st_nxt.modrm_byte);
    ilen = x86d_pkg::imm_len(x86d_pkg::form_of(st_nxt.first_byte), st_nxt.first_byte);
  end

  // Byte update and phase transition
  always_comb begin
    st_nxt    = st_r;
    phase_nxt = phase_r;
    fire      = 1'b0;
    err       = 1'b0;
    case (phase_r)
      PH_MODRM: begin
        st_nxt.byte_count = st_r.byte_count + 3'd1;
        st_nxt.modrm_byte = code_byte;
        if (form_cur == x86d_pkg::CL_IGRP && grp != x86d_pkg::GRP_ADD &&
            grp != x86d_pkg::GRP_SUB && grp != x86d_pkg::GRP_CMP) begin
          fire      = 1'b1;
          err       = 1'b1;
          phase_nxt = PH_OPC;
        end else if (dlen != 2'd0) begin
          phase_nxt = PH_DLO;
        end else if (ilen != 2'd0) begin
          phase_nxt = PH_ILO;
        end else begin
          fire      = 1'b1;
          phase_nxt = PH_OPC;
        end
      end
      PH_DLO: begin
        st_nxt.byte_count = st_r.byte_count + 3'd1;
        st_nxt.disp_acc   = {8'd0, code_byte};
        if (dlen == 2'd2) begin
          phase_nxt = PH_DHI;
        end else if (ilen != 2'd0) begin
          phase_nxt = PH_ILO;
        end else begin
          fire      = 1'b1;
          phase_nxt = PH_OPC;
        end
      end
      PH_DHI: begin
        st_nxt.byte_count = st_r.byte_count + 3'd1;
        st_nxt.disp_acc   = {code_byte, st_r.disp_acc[7:0]};
        if (ilen != 2'd0) begin
          phase_nxt = PH_ILO;
        end else begin
          fire      = 1'b1;
          phase_nxt = PH_OPC;
        end
      end
      PH_ILO: begin
        st_nxt.byte_count = st_r.byte_count + 3'd1;
        st_nxt.imm_acc    = {8'd0, code_byte};
        if (ilen == 2'd2) begin
          phase_nxt = PH_IHI;
        end else begin
          fire      = 1'b1;
          phase_nxt = PH_OPC;
        end
      end
      PH_IHI: begin
        st_nxt.byte_count = st_r.byte_count + 3'd1;
        st_nxt.imm_acc    = {code_byte, st_r.imm_acc[7:0]};
        fire              = 1'b1;
        phase_nxt         = PH_OPC;
      end
      default: begin
        // opcode wait: start a new instruction
        st_nxt.first_byte = code_byte;
        st_nxt.modrm_byte = 8'd0;
        st_nxt.disp_acc   = 16'd0;
        st_nxt.imm_acc    = 16'd0;
        st_nxt.byte_count = 3'd1;
        if (form_new == x86d_pkg::CL_NONE) begin
          fire      = 1'b1;
          err       = 1'b1;
          phase_nxt = PH_OPC;
        end else if (x86d_pkg::has_modrm(form_new)) begin
          phase_nxt = PH_MODRM;
        end else if (dlen != 2'd0) begin
          phase_nxt = PH_DLO;
        end else if (ilen != 2'd0) begin
          phase_nxt = PH_ILO;
        end else begin
          fire      = 1'b1;
          phase_nxt = PH_OPC;
        end
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPC;
      st_r    <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/x86d_record.sv =====
// Result record builder: maps the gathered instruction bytes to operand
// kinds, registers, displacement and immediate. Uses x86d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module x86d_record (
  input  wire x86d_pkg::dec_state_t st,
  input  wire logic                 err,
  output x86d_pkg::rec_t            rec
);

  x86d_pkg::form_t form;
  logic [7:0]      b;
  logic [2:0]      regf, rm;
  logic [1:0]      mod;
  logic [1:0]      rm_kind;
  logic [2:0]      rm_reg, rm_ea;
  logic [15:0]     rm_disp;
  logic [1:0]      rm_dbytes;

  assign b    = st.first_byte;
  assign form = x86d_pkg::form_of(b);
  assign regf = st.modrm_byte[5:3];
  assign rm   = st.modrm_byte[2:0];
  assign mod  = st.modrm_byte[7:6];

  // r/m operand with its displacement
  always_comb begin
    rm_kind   = x86d_pkg::KIND_REG;
    rm_reg    = 3'd0;
    rm_ea     = 3'd0;
    rm_disp   = 16'd0;
    rm_dbytes = 2'd0;
    if (mod == x86d_pkg::MOD_REG) begin
      rm_reg = rm;
    end else if (mod == x86d_pkg::MOD_NODISP && rm == x86d_pkg::RM_DIRECT) begin
      rm_kind   = x86d_pkg::KIND_DIRECT;
      rm_disp   = st.disp_acc;
      rm_dbytes = 2'd2;
    end else begin
      rm_kind = x86d_pkg::KIND_MEM;
      rm_ea   = rm;
      if (mod == x86d_pkg::MOD_DISP8) begin
        rm_disp   = {{8{st.disp_acc[7]}}, st.disp_acc[7:0]};
        rm_dbytes = 2'd1;
      end else if (mod == x86d_pkg::MOD_DISP16) begin
        rm_disp   = st.disp_acc;
        rm_dbytes = 2'd2;
      end
    end
  end

  // Record fields per instruction form
  always_comb begin
    rec        = '0;
    rec.length = st.byte_count;
    if (err) begin
      rec.status = 1'b1;
    end else begin
      case (form)
        x86d_pkg::CL_RM: begin
          if (b[7:2] == x86d_pkg::TOP6_MOV_RM) begin
            rec.op = x86d_pkg::OP_MOV;
          end else if (b[7:2] == x86d_pkg::TOP6_ADD_RM) begin
            rec.op = x86d_pkg::OP_ADD;
          end else if (b[7:2] == x86d_pkg::TOP6_SUB_RM) begin
            rec.op = x86d_pkg::OP_SUB;
          end else begin
            rec.op = x86d_pkg::OP_CMP;
          end
          rec.wide       = b[0];
          rec.ea_code    = rm_ea;
          rec.disp       = rm_disp;
          rec.disp_bytes = rm_dbytes;
          // D bit: reg field is the destination
          if (b[1]) begin
            rec.dst_kind = x86d_pkg::KIND_REG;
            rec.dst_reg  = regf;
            rec.src_kind = rm_kind;
            rec.src_reg  = rm_reg;
          end else begin
            rec.dst_kind = rm_kind;
            rec.dst_reg  = rm_reg;
            rec.src_kind = x86d_pkg::KIND_REG;
            rec.src_reg  = regf;
          end
        end
        x86d_pkg::CL_IMOV, x86d_pkg::CL_IGRP: begin
          if (form == x86d_pkg::CL_IMOV) begin
            rec.op  = x86d_pkg::OP_MOV;
            rec.imm = b[0] ? st.imm_acc : {8'd0, st.imm_acc[7:0]};
          end else begin
            if (regf == x86d_pkg::GRP_ADD) begin
              rec.op = x86d_pkg::OP_ADD;
            end else if (regf == x86d_pkg::GRP_SUB) begin
              rec.op = x86d_pkg::OP_SUB;
            end else begin
              rec.op = x86d_pkg::OP_CMP;
            end
            // sign-extended byte only when S and W are both set
            if (b[1] && b[0]) begin
              rec.imm = {{8{st.imm_acc[7]}}, st.imm_acc[7:0]};
            end else if (!b[0]) begin
              rec.imm = {8'd0, st.imm_acc[7:0]};
            end else begin
              rec.imm = st.imm_acc;
            end
          end
          rec.wide       = b[0];
          rec.dst_kind   = rm_kind;
          rec.dst_reg    = rm_reg;
          rec.ea_code    = rm_ea;
          rec.disp       = rm_disp;
          rec.disp_bytes = rm_dbytes;
          rec.src_kind   = x86d_pkg::KIND_IMM;
        end
        x86d_pkg::CL_IREG: begin
          rec.wide     = b[3];
          rec.dst_reg  = b[2:0];
          rec.src_kind = x86d_pkg::KIND_IMM;
          rec.imm      = b[3] ? st.imm_acc : {8'd0, st.imm_acc[7:0]};
        end
        x86d_pkg::CL_LOAD: begin
          rec.wide       = b[0];
          rec.src_kind   = x86d_pkg::KIND_DIRECT;
          rec.disp       = st.disp_acc;
          rec.disp_bytes = 2'd2;
        end
        default: begin
          // accumulator to direct memory
          rec.wide       = b[0];
          rec.dst_kind   = x86d_pkg::KIND_DIRECT;
          rec.disp       = st.disp_acc;
          rec.disp_bytes = 2'd2;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/x86_16_instruction_decoder.sv =====
// x86 16-bit decoder (mov/add/sub/cmp): one code byte per request.
// The last byte passes the input register, then is decoded into the result
// register, which drives out_valid.
// Throughput: one byte per cycle unless stalled; the result register frees its slot in the
// cycle it is taken, so in_stall only rises when a finished record is stalled.
// Reset: synchronous, active low; returns to opcode wait with both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module x86_16_instruction_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_code_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_status,
  output logic [1:0]       out_op,
  output logic             out_wide,
  output logic [1:0]       out_dst_kind,
  output logic [2:0]       out_dst_reg,
  output logic [1:0]       out_src_kind,
  output logic [2:0]       out_src_reg,
  output logic [2:0]       out_ea_code,
  output logic [15:0]      out_disp,
  output logic [1:0]       out_disp_bytes,
  output logic [15:0]      out_imm,
  output logic [2:0]       out_length
);

`include "x86_16_instruction_decoder_assert.svh"

  logic                 byte_valid_r;
  logic [7:0]           byte_r;
  logic                 slot_free, step, fire, err;
  x86d_pkg::dec_state_t st_nxt;
  x86d_pkg::rec_t       rec, rec_r;
  logic                 out_valid_r;

  // Pipeline control
  assign slot_free = !out_valid_r || !out_stall;
  assign step      = byte_valid_r && slot_free;
  assign in_stall  = byte_valid_r && !slot_free;

  x86d_gather u_gather (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .code_byte (byte_r),
    .st_nxt    (st_nxt),
    .fire      (fire),
    .err       (err)
  );

  x86d_record u_record (
    .st  (st_nxt),
    .err (err),
    .rec (rec)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      byte_valid_r <= 1'b1;
    end else if (step) begin
      byte_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_code_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && fire) begin
      rec_r <= rec;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = rec_r.status;
  assign out_op         = rec_r.op;
  assign out_wide       = rec_r.wide;
  assign out_dst_kind   = rec_r.dst_kind;
  assign out_dst_reg    = rec_r.dst_reg;
  assign out_src_kind   = rec_r.src_kind;
  assign out_src_reg    = rec_r.src_reg;
  assign out_ea_code    = rec_r.ea_code;
  assign out_disp       = rec_r.disp;
  assign out_disp_bytes = rec_r.disp_bytes;
  assign out_imm        = rec_r.imm;
  assign out_length     = rec_r.length;

  // Checks
  `X86D_ASSERT_IMP(a_stall_only_on_held_record, in_stall, out_valid && out_stall)
  `X86D_ASSERT_IMP(a_err_length, out_valid && out_status, out_length == 3'd1 || out_length == 3'd2)
  `X86D_ASSERT_IMP(a_ok_length, out_valid && !out_status, out_length != 3'd0 && out_length != 3'd7)
  `X86D_ASSERT_NEXT(a_record_loaded, step && fire, out_valid)

endmodule

`default_nettype wire
